// File: src/rsa_pkg.sv
// Shared types and constants for the RSA modular exponentiation engine.
// No dependencies; used by every module of the block.
`default_nettype none
package rsa_pkg;

   localparam int MOD_WIDTH_DEF   = 64;
   localparam int PRIME_WIDTH_DEF = 32;
   localparam int DATA_WIDTH      = 64;
   localparam int CSR_IDX_WIDTH   = 2;

   localparam logic [DATA_WIDTH-1:0] EXP_RESET = 64'd65537;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MODULUS  = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_EXPONENT = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PRIME_P  = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PRIME_Q  = 2'd3;

   typedef enum logic [1:0] {
      STS_OK         = 2'd0,
      STS_NO_INVERSE = 2'd1,
      STS_ZERO_MOD   = 2'd2
   } status_type;

   typedef struct packed {
      logic                  req_type;
      logic [DATA_WIDTH-1:0] in_value;
   } rsa_req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] out_value;
      logic [1:0]            status;
   } rsa_rsp_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_LOAD_ENC,
      OP_LOAD_DEC,
      OP_LOAD_TOT,
      OP_DIV_BASE,
      OP_DIV_EXP,
      OP_DIV_EUC,
      OP_SET_BASE,
      OP_EUC_INIT,
      OP_EUC_Q,
      OP_EUC_STEP,
      OP_EUC_FINISH,
      OP_EUC_NOINV,
      OP_POW_INIT,
      OP_MUL_INIT_SQ,
      OP_MUL_INIT_MB,
      OP_MUL_INIT_EQ,
      OP_MUL_DBL,
      OP_MUL_ADD,
      OP_ACC_TAKE,
      OP_EXP_SHIFT,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      status_type sts;
   } dp_cmd_type;

   typedef struct packed {
      logic req_dec;
      logic mod_zero;
      logic priv_valid;
      logic inv_missing;
      logic div_done;
      logic r_zero;
      logic exp_msb;
   } dp_stat_type;

endpackage
`default_nettype wire

// File: src/rsa_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rsa_pkg.
`default_nettype none
module rsa_div #(
   parameter int AW = rsa_pkg::MOD_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [rsa_pkg::DATA_WIDTH-1:0] dividend,
   input  wire logic [AW-1:0]                  divisor,
   output logic                                done,
   output logic [rsa_pkg::DATA_WIDTH-1:0]      quot,
   output logic [AW-1:0]                       rem
);
   localparam int DW = rsa_pkg::DATA_WIDTH;
   localparam int CW = $clog2(DW);
   localparam logic [CW-1:0] LAST = CW'(DW - 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [AW-1:0] rem_ff, rem_in;
   logic [AW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [AW:0]   shifted;
   logic [AW:0]   diff;
   logic          fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = shifted >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DW-2:0], fits};
         rem_in = fits ? diff[AW-1:0] : shifted[AW-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

// File: src/rsa_dp.sv
// Datapath: key registers, modular add/multiply steps, Euclid registers.
// Depends on rsa_pkg and rsa_div.
`default_nettype none
module rsa_dp #(
   parameter int MOD_WIDTH   = rsa_pkg::MOD_WIDTH_DEF,
   parameter int PRIME_WIDTH = rsa_pkg::PRIME_WIDTH_DEF,
   parameter int AW          = rsa_pkg::MOD_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [rsa_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [rsa_pkg::DATA_WIDTH-1:0]    csr_data,
   input  wire rsa_pkg::rsa_req_type              req_data,
   input  wire rsa_pkg::dp_cmd_type               cmd,
   output rsa_pkg::dp_stat_type                   stat,
   output rsa_pkg::rsa_rsp_type                   rsp_data
);
   localparam int DW = rsa_pkg::DATA_WIDTH;
   localparam int PW = PRIME_WIDTH;

   logic [MOD_WIDTH-1:0] n_ff, n_in, e_ff, e_in;
   logic [PW-1:0]        p_ff, p_in, q_ff, q_in;
   logic [AW-1:0]        priv_ff, priv_in;
   logic                 pvalid_ff, pvalid_in, nomiss_ff, nomiss_in;
   logic [DW-1:0]        value_ff, value_in;
   logic                 dec_ff, dec_in;
   logic [AW-1:0]        mod_ff, mod_in, base_ff, base_in, exp_ff, exp_in, acc_ff, acc_in;
   logic [AW-1:0]        mx_ff, mx_in, ma_ff, ma_in, mb_ff, mb_in;
   logic [AW-1:0]        or_ff, or_in, r_ff, r_in, os_ff, os_in, s_ff, s_in;
   logic [AW-1:0]        eq_ff, eq_in, nr_ff, nr_in;
   rsa_pkg::rsa_rsp_type out_ff, out_in;

   logic [PW-1:0]   pm, qm, mul_x, mul_y;
   logic [2*PW-1:0] prod;
   logic [AW-1:0]   add_y, add_r, quot_n, ns;
   logic [AW:0]     sum, dif;
   logic            div_start, div_done;
   logic [DW-1:0]   div_dvd, div_quot;
   logic [AW-1:0]   div_dvs, div_rem;

   rsa_div #(.AW(AW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   always_comb begin
      pm    = (p_ff == '0) ? PW'(1) : p_ff - 1'b1;
      qm    = (q_ff == '0) ? PW'(1) : q_ff - 1'b1;
      mul_x = (cmd.op == rsa_pkg::OP_LOAD_TOT) ? pm : p_ff;
      mul_y = (cmd.op == rsa_pkg::OP_LOAD_TOT) ? qm : q_ff;
      prod  = mul_x * mul_y;

      add_y = (cmd.op == rsa_pkg::OP_MUL_DBL) ? mx_ff : ma_ff;
      sum   = {1'b0, mx_ff} + {1'b0, add_y};
      dif   = sum - {1'b0, mod_ff};
      add_r = (sum >= {1'b0, mod_ff}) ? dif[AW-1:0] : sum[AW-1:0];

      quot_n = div_quot[AW-1:0];
      ns     = os_ff - mx_ff + ((os_ff < mx_ff) ? mod_ff : '0);

      div_start = 1'b0;
      div_dvd   = value_ff;
      div_dvs   = mod_ff;
      case (cmd.op)
         rsa_pkg::OP_DIV_BASE: div_start = 1'b1;
         rsa_pkg::OP_DIV_EXP: begin
            div_start = 1'b1;
            div_dvd   = DW'(e_ff);
         end
         rsa_pkg::OP_DIV_EUC: begin
            div_start = 1'b1;
            div_dvd   = DW'(or_ff);
            div_dvs   = r_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      n_in = n_ff; e_in = e_ff; p_in = p_ff; q_in = q_ff;
      priv_in = priv_ff; pvalid_in = pvalid_ff; nomiss_in = nomiss_ff;
      value_in = value_ff; dec_in = dec_ff;
      mod_in = mod_ff; base_in = base_ff; exp_in = exp_ff; acc_in = acc_ff;
      mx_in = mx_ff; ma_in = ma_ff; mb_in = mb_ff;
      or_in = or_ff; r_in = r_ff; os_in = os_ff; s_in = s_ff;
      eq_in = eq_ff; nr_in = nr_ff; out_in = out_ff;

      if (csr_we) begin
         pvalid_in = 1'b0;
         case (csr_index)
            rsa_pkg::CSR_MODULUS:  n_in = csr_data[MOD_WIDTH-1:0];
            rsa_pkg::CSR_EXPONENT: e_in = csr_data[MOD_WIDTH-1:0];
            rsa_pkg::CSR_PRIME_P:  p_in = csr_data[PW-1:0];
            rsa_pkg::CSR_PRIME_Q:  q_in = csr_data[PW-1:0];
            default:               pvalid_in = pvalid_ff;
         endcase
      end

      case (cmd.op)
         rsa_pkg::OP_ACCEPT: begin
            value_in = req_data.in_value;
            dec_in   = req_data.req_type;
         end
         rsa_pkg::OP_LOAD_ENC: begin
            mod_in = AW'(n_ff);
            exp_in = AW'(e_ff);
         end
         rsa_pkg::OP_LOAD_DEC: begin
            mod_in = AW'(prod);
            exp_in = priv_ff;
         end
         rsa_pkg::OP_LOAD_TOT: mod_in = AW'(prod);
         rsa_pkg::OP_SET_BASE: base_in = div_rem;
         rsa_pkg::OP_EUC_INIT: begin
            or_in = mod_ff;
            r_in  = div_rem;
            os_in = '0;
            s_in  = (mod_ff == AW'(1)) ? '0 : AW'(1);
         end
         rsa_pkg::OP_EUC_Q: begin
            eq_in = (quot_n >= mod_ff) ? quot_n - mod_ff : quot_n;
            nr_in = div_rem;
         end
         rsa_pkg::OP_EUC_STEP: begin
            or_in = r_ff;
            r_in  = nr_ff;
            os_in = s_ff;
            s_in  = ns;
         end
         rsa_pkg::OP_EUC_FINISH: begin
            nomiss_in = (or_ff != AW'(1));
            priv_in   = (or_ff != AW'(1)) ? '0 : os_ff;
            pvalid_in = 1'b1;
         end
         rsa_pkg::OP_EUC_NOINV: begin
            nomiss_in = 1'b1;
            priv_in   = '0;
            pvalid_in = 1'b1;
         end
         rsa_pkg::OP_POW_INIT: acc_in = (mod_ff == AW'(1)) ? '0 : AW'(1);
         rsa_pkg::OP_MUL_INIT_SQ: begin
            mx_in = '0;
            ma_in = acc_ff;
            mb_in = acc_ff;
         end
         rsa_pkg::OP_MUL_INIT_MB: begin
            mx_in = '0;
            ma_in = base_ff;
            mb_in = acc_ff;
         end
         rsa_pkg::OP_MUL_INIT_EQ: begin
            mx_in = '0;
            ma_in = eq_ff;
            mb_in = s_ff;
         end
         rsa_pkg::OP_MUL_DBL: mx_in = add_r;
         rsa_pkg::OP_MUL_ADD: begin
            if (mb_ff[AW-1]) begin
               mx_in = add_r;
            end
            mb_in = {mb_ff[AW-2:0], 1'b0};
         end
         rsa_pkg::OP_ACC_TAKE:  acc_in = mx_ff;
         rsa_pkg::OP_EXP_SHIFT: exp_in = {exp_ff[AW-2:0], 1'b0};
         rsa_pkg::OP_OUT: begin
            out_in.status = cmd.sts;
            if (cmd.sts != rsa_pkg::STS_OK) begin
               out_in.out_value = '0;
            end else if (dec_ff) begin
               out_in.out_value = DW'(acc_ff[7:0]);
            end else begin
               out_in.out_value = DW'(acc_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in; dec_ff <= dec_in;
      mod_ff <= mod_in; base_ff <= base_in; exp_ff <= exp_in; acc_ff <= acc_in;
      mx_ff <= mx_in; ma_ff <= ma_in; mb_ff <= mb_in;
      or_ff <= or_in; r_ff <= r_in; os_ff <= os_in; s_ff <= s_in;
      eq_ff <= eq_in; nr_ff <= nr_in; out_ff <= out_in;
      if (reset) begin
         n_ff      <= '0;
         e_ff      <= rsa_pkg::EXP_RESET[MOD_WIDTH-1:0];
         p_ff      <= '0;
         q_ff      <= '0;
         priv_ff   <= '0;
         pvalid_ff <= 1'b0;
         nomiss_ff <= 1'b0;
      end else begin
         n_ff      <= n_in;
         e_ff      <= e_in;
         p_ff      <= p_in;
         q_ff      <= q_in;
         priv_ff   <= priv_in;
         pvalid_ff <= pvalid_in;
         nomiss_ff <= nomiss_in;
      end
   end

   always_comb begin
      stat.req_dec     = dec_ff;
      stat.mod_zero    = (mod_ff == '0);
      stat.priv_valid  = pvalid_ff;
      stat.inv_missing = nomiss_ff;
      stat.div_done    = div_done;
      stat.r_zero      = (r_ff == '0);
      stat.exp_msb     = exp_ff[AW-1];
   end

   assign rsp_data = out_ff;

endmodule
`default_nettype wire

// File: src/rsa_ctrl.sv
// Controller state machine: sequences Euclid, exponentiation and modmul steps.
// Depends on rsa_pkg; drives rsa_dp through command and status structs.
`default_nettype none
module rsa_ctrl #(
   parameter int AW = rsa_pkg::MOD_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire rsa_pkg::dp_stat_type stat,
   output logic                      busy,
   output logic                      rsp_valid,
   output rsa_pkg::dp_cmd_type       cmd
);
   localparam int CW = $clog2(AW);
   localparam logic [CW-1:0] LAST = CW'(AW - 1);

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_TOT, S_TOT_CHK, S_EXPD_WAIT, S_EUC_TEST, S_EUC_WAIT,
      S_EQ_INIT, S_EQ_DONE, S_DEC_CHK, S_MCHK, S_BASE_WAIT, S_POW_INIT, S_SQ_INIT,
      S_SQ_DONE, S_MB_INIT, S_MB_DONE, S_EXP_NEXT, S_FINISH, S_MDBL, S_MADD
   } state_type;

   state_type     state_ff, state_in, ret_ff, ret_in;
   logic [CW-1:0] mcnt_ff, mcnt_in, pcnt_ff, pcnt_in;
   logic          busy_ff, busy_in, rspv_ff, rspv_in;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      mcnt_in  = mcnt_ff;
      pcnt_in  = pcnt_ff;
      rspv_in  = 1'b0;
      cmd.op   = rsa_pkg::OP_NONE;
      cmd.sts  = rsa_pkg::STS_OK;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = rsa_pkg::OP_ACCEPT;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!stat.req_dec) begin
               cmd.op   = rsa_pkg::OP_LOAD_ENC;
               state_in = S_MCHK;
            end else if (stat.priv_valid) begin
               state_in = S_DEC_CHK;
            end else begin
               state_in = S_TOT;
            end
         end
         S_TOT: begin
            cmd.op   = rsa_pkg::OP_LOAD_TOT;
            state_in = S_TOT_CHK;
         end
         S_TOT_CHK: begin
            if (stat.mod_zero) begin
               cmd.op   = rsa_pkg::OP_EUC_NOINV;
               state_in = S_DEC_CHK;
            end else begin
               cmd.op   = rsa_pkg::OP_DIV_EXP;
               state_in = S_EXPD_WAIT;
            end
         end
         S_EXPD_WAIT: begin
            if (stat.div_done) begin
               cmd.op   = rsa_pkg::OP_EUC_INIT;
               state_in = S_EUC_TEST;
            end
         end
         S_EUC_TEST: begin
            if (stat.r_zero) begin
               cmd.op   = rsa_pkg::OP_EUC_FINISH;
               state_in = S_DEC_CHK;
            end else begin
               cmd.op   = rsa_pkg::OP_DIV_EUC;
               state_in = S_EUC_WAIT;
            end
         end
         S_EUC_WAIT: begin
            if (stat.div_done) begin
               cmd.op   = rsa_pkg::OP_EUC_Q;
               state_in = S_EQ_INIT;
            end
         end
         S_EQ_INIT: begin
            cmd.op   = rsa_pkg::OP_MUL_INIT_EQ;
            mcnt_in  = '0;
            ret_in   = S_EQ_DONE;
            state_in = S_MDBL;
         end
         S_EQ_DONE: begin
            cmd.op   = rsa_pkg::OP_EUC_STEP;
            state_in = S_EUC_TEST;
         end
         S_DEC_CHK: begin
            if (stat.inv_missing) begin
               cmd.op   = rsa_pkg::OP_OUT;
               cmd.sts  = rsa_pkg::STS_NO_INVERSE;
               rspv_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.op   = rsa_pkg::OP_LOAD_DEC;
               state_in = S_MCHK;
            end
         end
         S_MCHK: begin
            if (stat.mod_zero) begin
               cmd.op   = rsa_pkg::OP_OUT;
               cmd.sts  = rsa_pkg::STS_ZERO_MOD;
               rspv_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.op   = rsa_pkg::OP_DIV_BASE;
               state_in = S_BASE_WAIT;
            end
         end
         S_BASE_WAIT: begin
            if (stat.div_done) begin
               cmd.op   = rsa_pkg::OP_SET_BASE;
               state_in = S_POW_INIT;
            end
         end
         S_POW_INIT: begin
            cmd.op   = rsa_pkg::OP_POW_INIT;
            pcnt_in  = '0;
            state_in = S_SQ_INIT;
         end
         S_SQ_INIT: begin
            cmd.op   = rsa_pkg::OP_MUL_INIT_SQ;
            mcnt_in  = '0;
            ret_in   = S_SQ_DONE;
            state_in = S_MDBL;
         end
         S_SQ_DONE: begin
            cmd.op   = rsa_pkg::OP_ACC_TAKE;
            state_in = stat.exp_msb ? S_MB_INIT : S_EXP_NEXT;
         end
         S_MB_INIT: begin
            cmd.op   = rsa_pkg::OP_MUL_INIT_MB;
            mcnt_in  = '0;
            ret_in   = S_MB_DONE;
            state_in = S_MDBL;
         end
         S_MB_DONE: begin
            cmd.op   = rsa_pkg::OP_ACC_TAKE;
            state_in = S_EXP_NEXT;
         end
         S_EXP_NEXT: begin
            cmd.op   = rsa_pkg::OP_EXP_SHIFT;
            pcnt_in  = pcnt_ff + 1'b1;
            state_in = (pcnt_ff == LAST) ? S_FINISH : S_SQ_INIT;
         end
         S_FINISH: begin
            cmd.op   = rsa_pkg::OP_OUT;
            rspv_in  = 1'b1;
            state_in = S_IDLE;
         end
         S_MDBL: begin
            cmd.op   = rsa_pkg::OP_MUL_DBL;
            state_in = S_MADD;
         end
         S_MADD: begin
            cmd.op   = rsa_pkg::OP_MUL_ADD;
            mcnt_in  = mcnt_ff + 1'b1;
            state_in = (mcnt_ff == LAST) ? ret_ff : S_MDBL;
         end
         default: state_in = S_IDLE;
      endcase
      busy_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         mcnt_ff  <= '0;
         pcnt_ff  <= '0;
         busy_ff  <= 1'b0;
         rspv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         mcnt_ff  <= mcnt_in;
         pcnt_ff  <= pcnt_in;
         busy_ff  <= busy_in;
         rspv_ff  <= rspv_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rspv_ff;

endmodule
`default_nettype wire

// File: src/rsa_modexp_engine.sv
// Top level of the RSA modular exponentiation engine.
// Depends on rsa_pkg, rsa_ctrl, rsa_dp (and rsa_div below it).
//
// Usage:
//   Request: a transaction is taken at a clock edge with start high and
//   busy low. req_data.req_type 0 encrypts (in_value^e mod n), 1 decrypts
//   (in_value^d mod p*q, low 8 bits returned).
//   Response: one transaction per request, rsp_valid high for one cycle
//   with rsp_data. The receiver cannot stall; the result must be taken then.
//   Configuration: csr_valid/csr_ready with csr_index 0..3 (n, e, p, q);
//   csr_ready is always high. Write only while busy is low. Any write drops
//   the cached private exponent.
//   Sequencing: a division reduces the input, then one step per exponent
//   bit, each a modular square plus an optional modular multiply.
//   A modmul is a setup, one double and one conditional add per bit, and a
//   writeback. The first decrypt after a configuration write also runs
//   extended Euclid: per step a division and one modmul. One transaction is
//   processed at a time.
//   Reset: synchronous; restores n = 0, e = 65537, p = q = 0, no cached key.
`default_nettype none
module rsa_modexp_engine #(
   parameter int MOD_WIDTH   = rsa_pkg::MOD_WIDTH_DEF,
   parameter int PRIME_WIDTH = rsa_pkg::PRIME_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire rsa_pkg::rsa_req_type              req_data,
   output logic                                   rsp_valid,
   output rsa_pkg::rsa_rsp_type                   rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [rsa_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [rsa_pkg::DATA_WIDTH-1:0]    csr_data
);
   localparam int AW = (MOD_WIDTH > 2 * PRIME_WIDTH) ? MOD_WIDTH : 2 * PRIME_WIDTH;

   rsa_pkg::dp_cmd_type  cmd;
   rsa_pkg::dp_stat_type stat;
   logic                 csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;

   rsa_ctrl #(.AW(AW)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   rsa_dp #(
      .MOD_WIDTH   (MOD_WIDTH),
      .PRIME_WIDTH (PRIME_WIDTH),
      .AW          (AW)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// File: src/rsa_chk.sv
// Port-level checker for rsa_modexp_engine, attached by bind.
// Depends on rsa_pkg.
`default_nettype none
module rsa_chk (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire rsa_pkg::rsa_req_type req_data,
   input wire logic                 rsp_valid,
   input wire rsa_pkg::rsa_rsp_type rsp_data
);
   logic dec_ff, dec_in;

   assign dec_in = (start && !busy) ? req_data.req_type : dec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff <= 1'b0;
      end else begin
         dec_ff <= dec_in;
      end
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised after request");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe longer than one cycle");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("response without a transaction");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != rsa_pkg::STS_OK) |-> (rsp_data.out_value == '0))
      else $error("error response with nonzero value");

   a_dec_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && dec_ff) |-> (rsp_data.out_value[63:8] == '0))
      else $error("decrypt result wider than a byte");

endmodule

bind rsa_modexp_engine rsa_chk u_rsa_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire
